@@ hdl/unp_pkg.sv @@
// ----------------------------------------------------------------------------
// unp_pkg
// Shared widths, constants, result type, digit decode and end clamp for the
// unsigned number parser.
// ----------------------------------------------------------------------------
package unp_pkg;

  // Field widths
  localparam int unsigned ValueBits  = 64;
  localparam int unsigned BaseBits   = 6;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned DigitBits  = 6;
  localparam int unsigned EndBits    = 16;
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned ProdBits   = ValueBits + BaseBits;

  // Radix constants
  localparam logic [BaseBits-1:0] BaseReset = BaseBits'(10);
  localparam logic [BaseBits-1:0] BaseAuto  = BaseBits'(0);
  localparam logic [BaseBits-1:0] BaseMin   = BaseBits'(2);
  localparam logic [BaseBits-1:0] BaseMax   = BaseBits'(36);
  localparam logic [BaseBits-1:0] BaseOct   = BaseBits'(8);
  localparam logic [BaseBits-1:0] BaseDec   = BaseBits'(10);
  localparam logic [BaseBits-1:0] BaseHex   = BaseBits'(16);

  // Character codes
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChTab   = 8'h09;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChLowA  = 8'h61;
  localparam logic [CharBits-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharBits-1:0] ChLowX  = 8'h78;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;

  localparam logic [DigitBits-1:0] NotDigit = '1;
  localparam logic [EndBits-1:0]   EndMax   = '1;

  // One result item
  typedef struct packed {
    logic [ValueBits-1:0] parsed_value;
    logic                 overflow_flag;
    logic                 converted_flag;
    logic [EndBits-1:0]   end_offset;
  } result_t;

  // Decode an ASCII byte into its digit value, or NotDigit
  function automatic logic [DigitBits-1:0] digit_value(input logic [CharBits-1:0] c);
    logic [CharBits-1:0] d;
    d = CharBits'(NotDigit);
    if (c inside {[ChZero:ChNine]}) begin
      d = c - ChZero;
    end else if (c inside {[ChLowA:ChLowZ]}) begin
      d = c - ChLowA + CharBits'(10);
    end else if (c inside {[ChUpA:ChUpZ]}) begin
      d = c - ChUpA + CharBits'(10);
    end else begin
      d = CharBits'(NotDigit);
    end
    return d[DigitBits-1:0];
  endfunction

  // Clamp a byte position to the end offset field
  function automatic logic [EndBits-1:0] sat_end(input logic [OffsetBits-1:0] p);
    if (33'(p) > 33'(EndMax)) begin
      return EndMax;
    end
    return EndBits'(p);
  endfunction

endpackage

@@ hdl/unp_in_if.sv @@
// ----------------------------------------------------------------------------
// unp_in_if
// Input byte channel: valid/ready handshake with one string byte per item.
// ----------------------------------------------------------------------------
interface unp_in_if;
  logic                          valid;
  logic                          ready;
  logic [unp_pkg::CharBits-1:0]  char_byte;
  logic                          string_start;

  modport source (output valid, output char_byte, output string_start, input ready);
  modport sink   (input valid, input char_byte, input string_start, output ready);
endinterface

@@ hdl/unp_out_if.sv @@
// ----------------------------------------------------------------------------
// unp_out_if
// Result channel: valid/ready handshake with one parsed number per item.
// ----------------------------------------------------------------------------
interface unp_out_if;
  logic                          valid;
  logic                          ready;
  logic [unp_pkg::ValueBits-1:0] parsed_value;
  logic                          overflow_flag;
  logic                          converted_flag;
  logic [unp_pkg::EndBits-1:0]   end_offset;

  modport source (output valid, output parsed_value, output overflow_flag,
                  output converted_flag, output end_offset, input ready);
  modport sink   (input valid, input parsed_value, input overflow_flag,
                  input converted_flag, input end_offset, output ready);
endinterface

@@ hdl/unp_core.sv @@
// ----------------------------------------------------------------------------
// unp_core
// Parse state and per-byte update: blank skip, prefix detection, digit
// multiply-accumulate with saturation, and result formation.
// ----------------------------------------------------------------------------
module unp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [unp_pkg::BaseBits-1:0]    cfg_wdata_i,
  input  logic                            item_acc_i,
  input  logic [unp_pkg::CharBits-1:0]    char_byte_i,
  input  logic                            string_start_i,
  output logic                            res_valid_o,
  output unp_pkg::result_t                res_o
);

  typedef enum logic [2:0] {
    PhDone,
    PhSkip,
    PhZero,
    PhHexFirst,
    PhDigits
  } phase_e;

  typedef enum logic [1:0] {
    StNone,
    StOk,
    StOvf
  } status_e;

  logic [unp_pkg::BaseBits-1:0]   number_base_q;
  phase_e                         phase_q, phase_d;
  logic [unp_pkg::BaseBits-1:0]   base_q, base_d;
  logic [unp_pkg::ValueBits-1:0]  acc_q, acc_d;
  status_e                        status_q, status_d;
  logic [unp_pkg::OffsetBits-1:0] pos_q, pos_d;

  logic [unp_pkg::DigitBits-1:0]  dig;
  logic [unp_pkg::ProdBits-1:0]   prod;
  logic                           is_blank;
  logic                           is_x;
  logic                           do_digit;
  logic                           digit_ok;
  logic                           emit_hex;
  logic                           emit;
  logic [unp_pkg::OffsetBits-1:0] end_pos;

  // Advance a position, holding at its maximum
  function automatic logic [unp_pkg::OffsetBits-1:0] adv(
    input logic [unp_pkg::OffsetBits-1:0] p
  );
    if (p == '1) begin
      return p;
    end
    return p + 1'b1;
  endfunction

  assign dig      = unp_pkg::digit_value(char_byte_i);
  assign is_blank = (char_byte_i == unp_pkg::ChSpace) || (char_byte_i == unp_pkg::ChTab);
  assign is_x     = (char_byte_i == unp_pkg::ChLowX) || (char_byte_i == unp_pkg::ChUpX);

  // Next parse state for the byte on the input
  always_comb begin
    phase_d  = phase_q;
    base_d   = base_q;
    acc_d    = acc_q;
    status_d = status_q;
    pos_d    = pos_q;
    do_digit = 1'b0;
    emit_hex = 1'b0;

    // Restart on a start byte
    if (string_start_i) begin
      phase_d  = PhSkip;
      base_d   = number_base_q;
      acc_d    = '0;
      status_d = StNone;
      pos_d    = '0;
    end

    case (phase_d)
      PhSkip: begin
        if (is_blank) begin
          pos_d = adv(pos_d);
        end else if (char_byte_i == unp_pkg::ChZero &&
                     (base_d == unp_pkg::BaseAuto || base_d == unp_pkg::BaseHex)) begin
          phase_d = PhZero;
          pos_d   = adv(pos_d);
        end else begin
          if (base_d == unp_pkg::BaseAuto) begin
            base_d = unp_pkg::BaseDec;
          end
          phase_d  = PhDigits;
          do_digit = 1'b1;
        end
      end
      PhZero: begin
        // The leading zero counts as a digit
        status_d = StOk;
        if (is_x) begin
          base_d  = unp_pkg::BaseHex;
          phase_d = PhHexFirst;
          pos_d   = adv(pos_d);
        end else begin
          if (base_d == unp_pkg::BaseAuto) begin
            base_d = unp_pkg::BaseOct;
          end
          phase_d  = PhDigits;
          do_digit = 1'b1;
        end
      end
      PhHexFirst: begin
        if (dig < unp_pkg::BaseHex) begin
          phase_d  = PhDigits;
          do_digit = 1'b1;
        end else begin
          emit_hex = 1'b1;
        end
      end
      PhDigits: begin
        do_digit = 1'b1;
      end
      default: begin
      end
    endcase

    // Multiply-accumulate one digit; the top bits flag overflow
    prod     = unp_pkg::ProdBits'(acc_d) * unp_pkg::ProdBits'(base_d) +
               unp_pkg::ProdBits'(dig);
    digit_ok = do_digit && (base_d >= unp_pkg::BaseMin) &&
               (base_d <= unp_pkg::BaseMax) && (dig < base_d);
    if (digit_ok) begin
      if (status_d == StOvf ||
          prod[unp_pkg::ProdBits-1:unp_pkg::ValueBits] != '0) begin
        status_d = StOvf;
      end else begin
        acc_d    = prod[unp_pkg::ValueBits-1:0];
        status_d = StOk;
      end
      pos_d = adv(pos_d);
    end

    // Terminate: a bare hex prefix ends at the x
    emit = (do_digit && !digit_ok) || emit_hex;
    if (emit_hex && pos_d != '1) begin
      end_pos = pos_d - 1'b1;
    end else begin
      end_pos = pos_d;
    end
    if (emit) begin
      phase_d = PhDone;
    end
  end

  // Form the result item
  always_comb begin
    res_o.parsed_value   = (status_d == StOvf) ? '1 : acc_d;
    res_o.overflow_flag  = (status_d == StOvf);
    res_o.converted_flag = (status_d != StNone);
    res_o.end_offset     = (status_d != StNone) ? unp_pkg::sat_end(end_pos) : '0;
  end

  assign res_valid_o = item_acc_i && emit;

  // Hold configuration and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= unp_pkg::BaseReset;
      phase_q       <= PhDone;
      base_q        <= '0;
      acc_q         <= '0;
      status_q      <= StNone;
      pos_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        number_base_q <= cfg_wdata_i;
      end
      if (item_acc_i) begin
        phase_q  <= phase_d;
        base_q   <= base_d;
        acc_q    <= acc_d;
        status_q <= status_d;
        pos_q    <= pos_d;
      end
    end
  end

endmodule

@@ hdl/unp_out_buf.sv @@
// ----------------------------------------------------------------------------
// unp_out_buf
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps moving while a result waits downstream.
// ----------------------------------------------------------------------------
module unp_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  unp_pkg::result_t push_data_i,
  output logic             in_ready_o,
  unp_out_if.source        out_o
);

  logic             head_valid_q, head_valid_d;
  logic             skid_valid_q, skid_valid_d;
  unp_pkg::result_t head_q, head_d;
  unp_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop        = head_valid_q && out_o.ready;
  assign in_ready_o = !skid_valid_q;

  // Move items between skid and head
  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!head_valid_q || pop) begin
        head_d       = push_data_i;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      head_valid_d = 1'b0;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_o.valid          = head_valid_q;
  assign out_o.parsed_value   = head_q.parsed_value;
  assign out_o.overflow_flag  = head_q.overflow_flag;
  assign out_o.converted_flag = head_q.converted_flag;
  assign out_o.end_offset     = head_q.end_offset;

endmodule

@@ hdl/unsigned_number_parser_saturating_top.sv @@
// ----------------------------------------------------------------------------
// unsigned_number_parser_saturating_top
// Streaming ASCII to unsigned 64-bit integer converter with saturation.
// ----------------------------------------------------------------------------
// Takes one string byte per item and accepts a new byte every cycle while
// input ready is high. Each byte is parsed combinationally: one 64x6
// multiply-add with an overflow check on its top bits updates the
// accumulator. A string's result is pushed into a two-entry output buffer
// when its terminating byte is accepted; input ready drops only when that
// buffer is full because the output side is stalled. The radix register is
// sampled on each start byte, so a write takes effect with the next string.
// ----------------------------------------------------------------------------
module unsigned_number_parser_saturating_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [unp_pkg::BaseBits-1:0] cfg_wdata_i,
  unp_in_if.sink                       in_i,
  unp_out_if.source                    out_o
);

  logic             item_acc;
  logic             buf_ready;
  logic             res_valid;
  unp_pkg::result_t res;

  assign in_i.ready = buf_ready;
  assign item_acc   = in_i.valid && buf_ready;

  // Parse state and digit datapath
  unp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_acc_i     (item_acc),
    .char_byte_i    (in_i.char_byte),
    .string_start_i (in_i.string_start),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Result buffer
  unp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .in_ready_o  (buf_ready),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // Overflow results saturate and count as converted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow_flag) |->
      (out_o.parsed_value == '1 && out_o.converted_flag))
    else $error("overflow result not saturated");

  // Nothing converted means zero value and zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.converted_flag) |->
      (out_o.parsed_value == '0 && out_o.end_offset == '0 && !out_o.overflow_flag))
    else $error("empty conversion result not cleared");

  // Input backpressure only follows a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_i.ready) |-> $past(out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");
`endif

endmodule

@@ bench/unsigned_number_parser_saturating_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_number_parser_saturating_top_tb
// Self-checking bench for the streaming unsigned number parser.
// ----------------------------------------------------------------------------
// Bytes go in over the input channel, one item per handshake. A local parser
// model runs on every accepted byte and queues the number it expects. Each
// result item is compared field by field with the oldest queued number. A
// table of directed strings comes first, then random strings grouped into
// segments, each with its own radix. Both channels stall at random in the
// first two of three idle phases and run without stalls in the third.
// ----------------------------------------------------------------------------
module unsigned_number_parser_saturating_top_tb;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainSettle = 4;
  localparam int unsigned PhaseItems  = 520;
  localparam int unsigned SegItems    = 115;

  localparam logic [unp_pkg::CharBits-1:0]   ChNul   = 8'h00;
  localparam logic [unp_pkg::OffsetBits-1:0] PosMax  = '1;
  localparam logic [unp_pkg::ValueBits-1:0]  AllOnes = '1;

  typedef enum logic [2:0] {
    ScanDone, ScanBlank, ScanZero, ScanHexFirst, ScanDigits
  } scan_phase_e;

  typedef enum logic [1:0] {
    DigitsNone, DigitsOk, DigitsOverflow
  } digit_status_e;

  // One directed string: radix, optional blank padding, text, closing byte
  typedef struct {
    logic [unp_pkg::BaseBits-1:0] radix;
    bit                           lead_start;
    int                           pad;
    string                        text;
    int                           tail;
    bit                           typed;
    unp_pkg::result_t             want;
  } string_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [unp_pkg::BaseBits-1:0] cfg_wdata_i;

  unp_in_if  in_bus ();
  unp_out_if out_bus ();

  unsigned_number_parser_saturating_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Parser model state
  logic [unp_pkg::BaseBits-1:0]   radix_reg   = unp_pkg::BaseReset;
  scan_phase_e                    scan_phase  = ScanDone;
  logic [unp_pkg::BaseBits-1:0]   scan_radix  = '0;
  logic [unp_pkg::ValueBits-1:0]  scan_acc    = '0;
  digit_status_e                  scan_status = DigitsNone;
  logic [unp_pkg::OffsetBits-1:0] scan_pos    = '0;

  unp_pkg::result_t pending_numbers[$];
  bit               want_typed = 1'b0;
  unp_pkg::result_t want_number;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      receiver_idle_pct = 0;

  // Directed strings; typed numbers only where they are obvious
  string_row_t plan[$] = '{
    '{unp_pkg::BaseDec, 1'b0, 0, "123", ChNul, 1'b0, '0},
    '{unp_pkg::BaseDec, 1'b1, 0, "18446744073709551615", ChNul, 1'b1,
      '{AllOnes, 1'b0, 1'b1, 16'd20}},
    '{unp_pkg::BaseDec, 1'b1, 0, "18446744073709551616", ChNul, 1'b1,
      '{AllOnes, 1'b1, 1'b1, 16'd20}},
    '{unp_pkg::BaseDec, 1'b1, 3, "42;junk", -1, 1'b0, '0},
    '{unp_pkg::BaseDec, 1'b1, 0, "987", -1, 1'b0, '0},
    '{unp_pkg::BaseDec, 1'b1, 0, "", 8'hFF, 1'b1, '{'0, 1'b0, 1'b0, 16'd0}},
    '{unp_pkg::BaseAuto, 1'b1, 0, "0", ChNul, 1'b1, '{'0, 1'b0, 1'b1, 16'd1}},
    '{unp_pkg::BaseAuto, 1'b1, 0, "0x", 8'h67, 1'b1, '{'0, 1'b0, 1'b1, 16'd1}},
    '{unp_pkg::BaseAuto, 1'b1, 0, "0755", ChNul, 1'b0, '0},
    '{unp_pkg::BaseAuto, 1'b1, 0, "0XfF", ChNul, 1'b0, '0},
    '{unp_pkg::BaseAuto, 1'b1, 0, "129", ChNul, 1'b0, '0},
    '{unp_pkg::BaseHex, 1'b1, 0, "0xFFFFFFFFFFFFFFFF", ChNul, 1'b1,
      '{AllOnes, 1'b0, 1'b1, 16'd18}},
    '{unp_pkg::BaseHex, 1'b1, 0, "0x1FFFFFFFFFFFFFFFF", ChNul, 1'b1,
      '{AllOnes, 1'b1, 1'b1, 16'd19}},
    '{unp_pkg::BaseHex, 1'b1, 0, "0", unp_pkg::ChUpZ, 1'b1,
      '{'0, 1'b0, 1'b1, 16'd1}},
    '{unp_pkg::BaseMin, 1'b1, 0, "1012", -1, 1'b0, '0},
    '{unp_pkg::BaseMax, 1'b1, 0, "zZ09", ChNul, 1'b0, '0},
    '{unp_pkg::BaseMax, 1'b1, 0, "zzzzzzzzzzzzzz", ChNul, 1'b1,
      '{AllOnes, 1'b1, 1'b1, 16'd14}},
    '{6'd1, 1'b1, 0, "5", ChNul, 1'b1, '{'0, 1'b0, 1'b0, 16'd0}},
    '{6'd37, 1'b1, 0, "1", ChNul, 1'b1, '{'0, 1'b0, 1'b0, 16'd0}},
    '{6'd63, 1'b1, 1, "7", ChNul, 1'b1, '{'0, 1'b0, 1'b0, 16'd0}},
    '{unp_pkg::BaseOct, 1'b1, 0, "0x12", ChNul, 1'b0, '0}
  };

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog
  initial begin
    wait (cycle_count == CycleLimit);
    $display("FAIL");
    $finish;
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // ---------------------------------------------------------------- model

  function automatic logic [unp_pkg::DigitBits-1:0] char_digit(
    input logic [unp_pkg::CharBits-1:0] c
  );
    if (c >= unp_pkg::ChZero && c <= unp_pkg::ChNine) begin
      return unp_pkg::DigitBits'(c - unp_pkg::ChZero);
    end
    if (c >= unp_pkg::ChLowA && c <= unp_pkg::ChLowZ) begin
      return unp_pkg::DigitBits'(c - unp_pkg::ChLowA + 8'd10);
    end
    if (c >= unp_pkg::ChUpA && c <= unp_pkg::ChUpZ) begin
      return unp_pkg::DigitBits'(c - unp_pkg::ChUpA + 8'd10);
    end
    return unp_pkg::NotDigit;
  endfunction

  function automatic void bump_pos();
    if (scan_pos != PosMax) begin
      scan_pos = scan_pos + 1'b1;
    end
  endfunction

  // Close the string and build its number
  function automatic void close_number(input logic [unp_pkg::OffsetBits-1:0] stop_pos,
                                       output bit emitted, output unp_pkg::result_t num);
    bit ovf;
    bit conv;
    ovf  = (scan_status == DigitsOverflow);
    conv = (scan_status != DigitsNone);
    num.parsed_value   = ovf ? AllOnes : scan_acc;
    num.overflow_flag  = ovf;
    num.converted_flag = conv;
    // offset and end field share a width, so no clamp is needed here
    num.end_offset     = conv ? unp_pkg::EndBits'(stop_pos) : '0;
    scan_phase = ScanDone;
    emitted = 1'b1;
  endfunction

  // Take the byte as a digit of the current radix, or end the string on it
  function automatic void take_or_close(input logic [unp_pkg::CharBits-1:0] c,
                                        output bit emitted, output unp_pkg::result_t num);
    logic [unp_pkg::DigitBits-1:0] d;
    logic [unp_pkg::ProdBits-1:0]  wide;
    d = char_digit(c);
    emitted = 1'b0;
    num = '0;
    if (scan_radix >= unp_pkg::BaseMin && scan_radix <= unp_pkg::BaseMax &&
        d < scan_radix) begin
      wide = unp_pkg::ProdBits'(scan_acc) * unp_pkg::ProdBits'(scan_radix) +
             unp_pkg::ProdBits'(d);
      if (scan_status == DigitsOverflow ||
          wide[unp_pkg::ProdBits-1:unp_pkg::ValueBits] != '0) begin
        scan_status = DigitsOverflow;
      end else begin
        scan_acc    = wide[unp_pkg::ValueBits-1:0];
        scan_status = DigitsOk;
      end
      bump_pos();
    end else begin
      close_number(scan_pos, emitted, num);
    end
  endfunction

  // Advance the parser model by one accepted byte
  function automatic void parse_char(input logic [unp_pkg::CharBits-1:0] c,
                                     input bit first,
                                     output bit emitted, output unp_pkg::result_t num);
    emitted = 1'b0;
    num = '0;
    if (first) begin
      scan_phase  = ScanBlank;
      scan_radix  = radix_reg;
      scan_acc    = '0;
      scan_status = DigitsNone;
      scan_pos    = '0;
    end
    case (scan_phase)
      ScanBlank: begin
        if (c == unp_pkg::ChSpace || c == unp_pkg::ChTab) begin
          bump_pos();
        end else if (c == unp_pkg::ChZero &&
                     (scan_radix == unp_pkg::BaseAuto || scan_radix == unp_pkg::BaseHex)) begin
          scan_phase = ScanZero;
          bump_pos();
        end else begin
          if (scan_radix == unp_pkg::BaseAuto) begin
            scan_radix = unp_pkg::BaseDec;
          end
          scan_phase = ScanDigits;
          take_or_close(c, emitted, num);
        end
      end
      ScanZero: begin
        // the leading zero itself counts as a converted digit
        scan_status = DigitsOk;
        if (c == unp_pkg::ChLowX || c == unp_pkg::ChUpX) begin
          scan_radix = unp_pkg::BaseHex;
          scan_phase = ScanHexFirst;
          bump_pos();
        end else begin
          if (scan_radix == unp_pkg::BaseAuto) begin
            scan_radix = unp_pkg::BaseOct;
          end
          scan_phase = ScanDigits;
          take_or_close(c, emitted, num);
        end
      end
      ScanHexFirst: begin
        if (char_digit(c) < unp_pkg::BaseHex) begin
          scan_phase = ScanDigits;
          take_or_close(c, emitted, num);
        end else begin
          // no hex digit after the prefix: the number ends at the x
          close_number((scan_pos == PosMax) ? scan_pos : scan_pos - 1'b1, emitted, num);
        end
      end
      ScanDigits: begin
        take_or_close(c, emitted, num);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Track config writes, predict on accepted bytes, check result items
  always @(posedge clk_i) begin
    unp_pkg::result_t seen;
    unp_pkg::result_t due;
    unp_pkg::result_t guess;
    bit               emitted;
    if (rst_ni) begin
      if (cfg_we_i) begin
        radix_reg = cfg_wdata_i;
      end
      if (in_bus.valid && in_bus.ready) begin
        parse_char(in_bus.char_byte, in_bus.string_start, emitted, guess);
        if (emitted) begin
          pending_numbers.push_back(want_typed ? want_number : guess);
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        seen.parsed_value   = out_bus.parsed_value;
        seen.overflow_flag  = out_bus.overflow_flag;
        seen.converted_flag = out_bus.converted_flag;
        seen.end_offset     = out_bus.end_offset;
        if (pending_numbers.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item: expected none, actual %p", $time, seen);
        end else begin
          due = pending_numbers.pop_front();
          check_field("parsed_value", due.parsed_value, seen.parsed_value);
          check_field("overflow_flag", 64'(due.overflow_flag), 64'(seen.overflow_flag));
          check_field("converted_flag", 64'(due.converted_flag),
                      64'(seen.converted_flag));
          check_field("end_offset", 64'(due.end_offset), 64'(seen.end_offset));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one byte, idling first at random; return at the next falling edge
  task automatic send_byte(input logic [unp_pkg::CharBits-1:0] c, input bit first);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.char_byte    <= c;
    in_bus.string_start <= first;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  // Hold the input until every queued number has come back
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_numbers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainSettle) @(negedge clk_i);
  endtask

  task automatic set_radix(input logic [unp_pkg::BaseBits-1:0] radix);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= radix;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [unp_pkg::CharBits-1:0] digit_char(input int unsigned v);
    if (v < 10) begin
      return unp_pkg::ChZero + unp_pkg::CharBits'(v);
    end
    return ($urandom_range(0, 1) ? unp_pkg::ChUpA : unp_pkg::ChLowA) +
           unp_pkg::CharBits'(v - 10);
  endfunction

  function automatic logic [unp_pkg::BaseBits-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0, 1, 2: return unp_pkg::BaseAuto;
      3, 4:    return unp_pkg::BaseHex;
      5:       return unp_pkg::BaseDec;
      6:       return unp_pkg::BaseOct;
      7, 8:    return unp_pkg::BaseBits'($urandom_range(2, 36));
      default: return $urandom_range(0, 1) ? 6'd1 : unp_pkg::BaseBits'($urandom_range(37, 63));
    endcase
  endfunction

  // One random string: blanks, maybe a prefix, digits, usually a terminator
  task automatic send_random_string(output int unsigned n_items);
    logic [unp_pkg::CharBits-1:0] text_q[$];
    int unsigned                  eff_radix;
    int unsigned                  kind;
    int unsigned                  n_dig;
    bit                           dropped;
    // stray bytes without a start flag
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(unp_pkg::CharBits'($urandom_range(0, 255)), 1'b0);
      end
    end
    repeat ($urandom_range(0, 3)) begin
      text_q.push_back($urandom_range(0, 1) ? unp_pkg::ChSpace : unp_pkg::ChTab);
    end
    eff_radix = int'(radix_reg);
    if (radix_reg == unp_pkg::BaseAuto || radix_reg == unp_pkg::BaseHex) begin
      kind = $urandom_range(0, 2);
      if (kind != 0) begin
        text_q.push_back(unp_pkg::ChZero);
      end
      if (kind == 2) begin
        text_q.push_back($urandom_range(0, 1) ? unp_pkg::ChLowX : unp_pkg::ChUpX);
      end
      if (radix_reg == unp_pkg::BaseAuto) begin
        eff_radix = (kind == 0) ? int'(unp_pkg::BaseDec) :
                    (kind == 1) ? int'(unp_pkg::BaseOct) : int'(unp_pkg::BaseHex);
      end
    end
    if (eff_radix < unp_pkg::BaseMin || eff_radix > unp_pkg::BaseMax) begin
      eff_radix = int'(unp_pkg::BaseMax);
    end
    n_dig = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
    repeat (n_dig) text_q.push_back(digit_char($urandom_range(0, eff_radix - 1)));
    dropped = ($urandom_range(0, 9) == 0);
    if (!dropped) begin
      text_q.push_back($urandom_range(0, 1) ? ChNul :
                       unp_pkg::CharBits'($urandom_range(0, 255)));
    end
    if (text_q.size() == 0) begin
      text_q.push_back(unp_pkg::CharBits'($urandom_range(0, 255)));
    end
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == 0);
    end
    n_items = text_q.size();
    // trailing bytes after the end are ignored by the parser
    if (!dropped && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(unp_pkg::CharBits'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // One segment: a fresh radix, then strings until enough bytes went in
  task automatic run_segment(output int unsigned n_items);
    int unsigned k;
    set_radix(pick_radix());
    n_items = 0;
    while (n_items < SegItems) begin
      send_random_string(k);
      n_items += k;
    end
    // close a string left open so the next write finds the parser idle
    send_byte(ChNul, 1'b0);
  endtask

  task automatic run_phase();
    int unsigned total;
    int unsigned n;
    total = 0;
    while (total < PhaseItems) begin
      run_segment(n);
      total += n;
    end
  endtask

  // Walk the directed table
  task automatic run_plan();
    bit first;
    foreach (plan[i]) begin
      if (plan[i].radix != radix_reg) begin
        set_radix(plan[i].radix);
      end
      want_typed  = plan[i].typed;
      want_number = plan[i].want;
      first = plan[i].lead_start;
      for (int k = 0; k < plan[i].pad; k++) begin
        send_byte((k % 2) ? unp_pkg::ChTab : unp_pkg::ChSpace, first);
        first = 1'b0;
      end
      for (int j = 0; j < plan[i].text.len(); j++) begin
        send_byte(plan[i].text[j], first);
        first = 1'b0;
      end
      if (plan[i].tail >= 0) begin
        send_byte(unp_pkg::CharBits'(plan[i].tail), first);
      end
    end
    want_typed = 1'b0;
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_bus.valid        = 1'b0;
    in_bus.char_byte    = '0;
    in_bus.string_start = 1'b0;
    out_bus.ready       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct   = 29;
    receiver_idle_pct = 55;
    run_plan();
    run_phase();

    sender_idle_pct   = 55;
    receiver_idle_pct = 29;
    run_phase();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_phase();

    drain();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/unp_pkg.sv
hdl/unp_in_if.sv
hdl/unp_out_if.sv
hdl/unp_core.sv
hdl/unp_out_buf.sv
hdl/unsigned_number_parser_saturating_top.sv
bench/unsigned_number_parser_saturating_top_tb.sv
